>>> src/lift_stepper_controller_macros.svh
// ---------------------------------------------------------------------------
// Lift stepper controller assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LIFT_STEPPER_CONTROLLER_MACROS_SVH
`define LIFT_STEPPER_CONTROLLER_MACROS_SVH

// same-cycle implication
`define LSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lsc_pkg.sv
// ---------------------------------------------------------------------------
// Lift stepper controller package
// Codes, item and result types, configuration bundle and coil table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsc_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_GOTO = 2'd1;
  localparam logic [1:0] CMD_ACK  = 2'd2;

  localparam logic [2:0] MODE_STAND   = 3'd0;
  localparam logic [2:0] MODE_UP      = 3'd1;
  localparam logic [2:0] MODE_DOWN    = 3'd2;
  localparam logic [2:0] MODE_HOME    = 3'd3;
  localparam logic [2:0] MODE_RELEASE = 3'd4;
  localparam logic [2:0] MODE_FAULT   = 3'd5;

  localparam logic [1:0] CFG_STEP_INTERVAL   = 2'd0;
  localparam logic [1:0] CFG_TRAVEL_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_RELEASE_TIMEOUT = 2'd2;

  localparam logic [31:0] STEP_INTERVAL_RST   = 32'd2000;
  localparam logic [31:0] TRAVEL_TIMEOUT_RST  = 32'd20000000;
  localparam logic [31:0] RELEASE_TIMEOUT_RST = 32'd5000000;
  localparam logic [31:0] TIMER_MAX           = 32'hFFFF_FFFF;

  localparam logic [1:0] FLOOR_GROUND = 2'd0;
  localparam logic [1:0] FLOOR_FIRST  = 2'd1;
  localparam logic [1:0] FLOOR_SECOND = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] target_floor;
    logic       reed_ground;
    logic       reed_first;
    logic       reed_second;
    logic       overtravel_top;
  } item_t;

  typedef struct packed {
    logic [3:0] coils;
    logic [2:0] mode;
    logic [1:0] floor_now;
    logic [1:0] floor_goal;
    logic       going_up;
  } result_t;

  typedef struct packed {
    logic [31:0] step_interval;
    logic [31:0] travel_timeout;
    logic [31:0] release_timeout;
  } cfg_t;

  function automatic logic [3:0] coil_of(input logic [1:0] ph);
    logic [3:0] pat;
    case (ph)
      2'd0:    pat = 4'h3;
      2'd1:    pat = 4'h6;
      2'd2:    pat = 4'hC;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

>>> src/lsc_in_if.sv
// ---------------------------------------------------------------------------
// Lift stepper controller request channel
// Valid/ready channel carrying one command with switch levels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] target_floor;
  logic       reed_ground;
  logic       reed_first;
  logic       reed_second;
  logic       overtravel_top;

  modport source (
    output valid, command, target_floor, reed_ground, reed_first, reed_second,
           overtravel_top,
    input  ready
  );
  modport sink (
    input  valid, command, target_floor, reed_ground, reed_first, reed_second,
           overtravel_top,
    output ready
  );
endinterface

>>> src/lsc_out_if.sv
// ---------------------------------------------------------------------------
// Lift stepper controller result channel
// Valid/ready channel carrying coil drive and status after each request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lsc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coils;
  logic [2:0] mode;
  logic [1:0] floor_now;
  logic [1:0] floor_goal;
  logic       going_up;

  modport source (
    output valid, coils, mode, floor_now, floor_goal, going_up,
    input  ready
  );
  modport sink (
    input  valid, coils, mode, floor_now, floor_goal, going_up,
    output ready
  );
endinterface

>>> src/lsc_cfg_if.sv
// ---------------------------------------------------------------------------
// Lift stepper controller configuration channel
// Valid/ready register write channel: register index and write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/lsc_cfg_regs.sv
// ---------------------------------------------------------------------------
// Lift stepper controller configuration registers
// Step interval and the two timeouts, written through the config channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  lsc_cfg_if.sink       cfg_ch,
  output lsc_pkg::cfg_t cfg
);
  import lsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid & cfg_ch.ready;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_ch.index)
        CFG_STEP_INTERVAL:   cfg_nxt.step_interval   = cfg_ch.data;
        CFG_TRAVEL_TIMEOUT:  cfg_nxt.travel_timeout  = cfg_ch.data;
        CFG_RELEASE_TIMEOUT: cfg_nxt.release_timeout = cfg_ch.data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_interval   <= STEP_INTERVAL_RST;
      cfg_r.travel_timeout  <= TRAVEL_TIMEOUT_RST;
      cfg_r.release_timeout <= RELEASE_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> src/lsc_ctrl.sv
// ---------------------------------------------------------------------------
// Lift stepper controller core
// Mode, floors, step phase, direction and timers; next state per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lift_stepper_controller_macros.svh"

module lsc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  lsc_pkg::item_t   item,
  input  lsc_pkg::cfg_t    cfg,
  output lsc_pkg::result_t res_nxt
);
  import lsc_pkg::*;

  logic [2:0]  mode_r,   mode_nxt;
  logic [1:0]  known_r,  known_nxt;
  logic [1:0]  goal_r,   goal_nxt;
  logic [1:0]  phase_r,  phase_nxt;
  logic        up_r,     up_nxt;
  logic [3:0]  coil_r,   coil_nxt;
  logic [31:0] step_tmr_r, step_tmr_nxt;
  logic [31:0] run_tmr_r,  run_tmr_nxt;

  logic [31:0] step_inc;
  logic [31:0] run_inc;
  logic [1:0]  tracked;
  logic        any_reed;
  logic        step_due;
  logic [1:0]  phase_stp;
  logic        goto_ok;
  logic        goto_up;

  assign step_inc  = (step_tmr_r == TIMER_MAX) ? step_tmr_r : step_tmr_r + 32'd1;
  assign run_inc   = (run_tmr_r == TIMER_MAX) ? run_tmr_r : run_tmr_r + 32'd1;
  assign any_reed  = item.reed_ground | item.reed_first | item.reed_second;
  assign step_due  = step_inc >= cfg.step_interval;
  assign phase_stp = up_r ? phase_r + 2'd1 : phase_r + 2'd3;

  always_comb begin
    if (item.reed_ground)      tracked = FLOOR_GROUND;
    else if (item.reed_first)  tracked = FLOOR_FIRST;
    else if (item.reed_second) tracked = FLOOR_SECOND;
    else                       tracked = known_r;
  end

  assign goto_ok = (item.target_floor != 2'd3) &&
                   (mode_r == MODE_UP || mode_r == MODE_DOWN || mode_r == MODE_STAND) &&
                   !(mode_r == MODE_STAND && item.target_floor == known_r);

  always_comb begin
    if (item.target_floor > known_r)      goto_up = 1'b1;
    else if (item.target_floor < known_r) goto_up = 1'b0;
    else                                  goto_up = (mode_r == MODE_DOWN);
  end

  always_comb begin
    mode_nxt     = mode_r;
    known_nxt    = known_r;
    goal_nxt     = goal_r;
    phase_nxt    = phase_r;
    up_nxt       = up_r;
    coil_nxt     = coil_r;
    step_tmr_nxt = step_tmr_r;
    run_tmr_nxt  = run_tmr_r;
    case (item.command)
      CMD_TICK: begin
        step_tmr_nxt = step_inc;
        run_tmr_nxt  = run_inc;
        case (mode_r)
          MODE_UP, MODE_DOWN, MODE_HOME: begin
            if (item.overtravel_top) begin
              up_nxt       = 1'b0;
              step_tmr_nxt = '0;
              run_tmr_nxt  = '0;
              mode_nxt     = MODE_RELEASE;
            end else if (run_inc > cfg.travel_timeout) begin
              coil_nxt = '0;
              mode_nxt = MODE_FAULT;
            end else if (mode_r == MODE_HOME && any_reed) begin
              known_nxt = tracked;
              coil_nxt  = '0;
              mode_nxt  = MODE_STAND;
            end else if (mode_r != MODE_HOME && tracked == goal_r) begin
              known_nxt = tracked;
              coil_nxt  = '0;
              mode_nxt  = MODE_STAND;
            end else begin
              known_nxt = tracked;
              if (step_due) begin
                step_tmr_nxt = '0;
                phase_nxt    = phase_stp;
                coil_nxt     = coil_of(phase_stp);
              end
            end
          end
          MODE_RELEASE: begin
            if (item.reed_second) begin
              known_nxt = FLOOR_SECOND;
              coil_nxt  = '0;
              mode_nxt  = MODE_STAND;
            end else if (run_inc > cfg.release_timeout) begin
              coil_nxt = '0;
              mode_nxt = MODE_STAND;
            end else if (step_due) begin
              step_tmr_nxt = '0;
              phase_nxt    = phase_stp;
              coil_nxt     = coil_of(phase_stp);
            end
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
      end
      CMD_GOTO: begin
        if (goto_ok) begin
          goal_nxt     = item.target_floor;
          run_tmr_nxt  = '0;
          step_tmr_nxt = '0;
          up_nxt       = goto_up;
          mode_nxt     = goto_up ? MODE_UP : MODE_DOWN;
        end
      end
      CMD_ACK: begin
        if (mode_r == MODE_FAULT) begin
          coil_nxt = '0;
          mode_nxt = MODE_STAND;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  assign res_nxt.coils      = coil_nxt;
  assign res_nxt.mode       = mode_nxt;
  assign res_nxt.floor_now  = known_nxt;
  assign res_nxt.floor_goal = goal_nxt;
  assign res_nxt.going_up   = up_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_HOME;
      known_r    <= FLOOR_GROUND;
      goal_r     <= FLOOR_GROUND;
      phase_r    <= '0;
      up_r       <= 1'b1;
      coil_r     <= '0;
      step_tmr_r <= '0;
      run_tmr_r  <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      known_r    <= known_nxt;
      goal_r     <= goal_nxt;
      phase_r    <= phase_nxt;
      up_r       <= up_nxt;
      coil_r     <= coil_nxt;
      step_tmr_r <= step_tmr_nxt;
      run_tmr_r  <= run_tmr_nxt;
    end
  end

  `LSC_ASSERT_IMP(a_coils_off_idle, mode_r == MODE_STAND || mode_r == MODE_FAULT, coil_r == 4'h0, "coils driven while stopped")
  `LSC_ASSERT_IMP(a_coils_match_phase, coil_r != 4'h0, coil_r == coil_of(phase_r), "coil pattern out of step with phase")
  `LSC_ASSERT_NXT(a_fault_sticky, mode_r == MODE_FAULT && !(fire && item.command == CMD_ACK), mode_r == MODE_FAULT, "fault left without acknowledge")
  `LSC_ASSERT_NXT(a_ack_clears, fire && item.command == CMD_ACK && mode_r == MODE_FAULT, mode_r == MODE_STAND, "acknowledge did not clear fault")

endmodule

>>> src/lift_stepper_controller.sv
// ---------------------------------------------------------------------------
// Lift stepper controller
// Three-floor lift control with full-step four-coil stepper drive.
// ---------------------------------------------------------------------------
// Requests arrive on in_ch: a tick with reed and overtravel switch levels,
// a goto-floor request, or a fault acknowledge. Every request yields one
// result on out_ch: coil pattern, mode, known floor, goal floor, direction.
// cfg_ch writes step_interval, travel_timeout and release_timeout; it is
// always ready. The user must see that it is written only while no request
// is in flight; the block itself does not enforce this. The input register
// takes a request when in_ch accepts it, and the result register loads from
// it when out_ch can advance; out_ch.valid is high while a result is held.
// Throughput: one request per cycle while out_ch does not stall; the state
// update is a single pass of compare/increment logic on 32-bit timers.
// When out_ch stalls, the result register holds and the input register
// fills; in_ch.ready drops only when both are occupied.
// Reset (synchronous, rst_n low) loads the default register values and
// starts a homing run upward with the motor off until the first step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lift_stepper_controller (
  input  logic      clk,
  input  logic      rst_n,
  lsc_in_if.sink    in_ch,
  lsc_out_if.source out_ch,
  lsc_cfg_if.sink   cfg_ch
);
  import lsc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;
  logic    fire;
  logic    take;

  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  lsc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  lsc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.command        <= in_ch.command;
      item_r.target_floor   <= in_ch.target_floor;
      item_r.reed_ground    <= in_ch.reed_ground;
      item_r.reed_first     <= in_ch.reed_first;
      item_r.reed_second    <= in_ch.reed_second;
      item_r.overtravel_top <= in_ch.overtravel_top;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.coils      = res_r.coils;
  assign out_ch.mode       = res_r.mode;
  assign out_ch.floor_now  = res_r.floor_now;
  assign out_ch.floor_goal = res_r.floor_goal;
  assign out_ch.going_up   = res_r.going_up;

endmodule
